// File: hdl/tiv_pkg.sv
// Shared constants for the turbulent inlet velocity block.
`default_nettype none
package tiv_pkg;
  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] KEY_Y  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] KEY_Z  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] KEY_T  = 64'h94d049bb133111eb;
  localparam int MIX_SHIFT = 33;
  localparam int UNIT_BITS = 53;

  localparam logic [2:0] REG_CENTER    = 3'd0;
  localparam logic [2:0] REG_NORMAL    = 3'd1;
  localparam logic [2:0] REG_RADIUS    = 3'd2;
  localparam logic [2:0] REG_PEAK      = 3'd3;
  localparam logic [2:0] REG_INTENSITY = 3'd4;
  localparam logic [2:0] REG_WARM_UP   = 3'd5;
  localparam logic [2:0] REG_SEED      = 3'd6;
  localparam logic [2:0] REG_PERIOD    = 3'd7;
endpackage
`default_nettype wire

// File: hdl/tiv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module tiv_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int Q_W   = 32
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quo
);
  localparam int REM_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [REM_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [REM_W-1:0] dsh;
    if (j == 0) begin : g_first
      assign rem_in = REM_W'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end
    assign dsh = REM_W'(den_in) << (Q_W - 1 - j);
    always_ff @(posedge clk) begin
      den_q[j] <= den_in;
      if (rem_in >= dsh) begin
        rem_q[j] <= rem_in - dsh;
        quo_q[j] <= quo_in | (Q_W'(1) << (Q_W - 1 - j));
      end else begin
        rem_q[j] <= rem_in;
        quo_q[j] <= quo_in;
      end
    end
  end

  assign quo = quo_q[Q_W-1];
endmodule
`default_nettype wire

// File: hdl/tiv_fmix.sv
// Four-stage pipelined 64-bit fmix finalizer.
`default_nettype none
module tiv_fmix
  import tiv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [63:0] key,
  output logic      [63:0] hash
);
  logic [63:0] k1, m1, m2;
  logic [63:0] p1_ll, p2_ll, k2;
  logic [31:0] p1_hl, p1_lh, p2_hl, p2_lh;

  assign k1 = key ^ (key >> MIX_SHIFT);
  assign m1 = p1_ll + {32'(p1_hl + p1_lh), 32'd0};
  assign m2 = p2_ll + {32'(p2_hl + p2_lh), 32'd0};

  always_ff @(posedge clk) begin
    p1_ll <= 64'(k1[31:0]) * 64'(MIX_C1[31:0]);
    p1_hl <= 32'(k1[63:32] * MIX_C1[31:0]);
    p1_lh <= 32'(k1[31:0] * MIX_C1[63:32]);
    k2    <= m1 ^ (m1 >> MIX_SHIFT);
    p2_ll <= 64'(k2[31:0]) * 64'(MIX_C2[31:0]);
    p2_hl <= 32'(k2[63:32] * MIX_C2[31:0]);
    p2_lh <= 32'(k2[31:0] * MIX_C2[63:32]);
    hash  <= m2 ^ (m2 >> MIX_SHIFT);
  end
endmodule
`default_nettype wire

// File: hdl/turbulent_inlet_velocity.sv
// Top level: pipelined inlet velocity with parabolic profile and hash noise.
//
//  channel  | handshake       | payload
//  ---------+-----------------+------------------------------------------
//  input    | start / busy    | site_x, site_y, site_z, time_step
//  result   | done (1 cycle)  | vel_x, vel_y, vel_z, outside_radius
//  config   | wr_en           | wr_index, wr_data
//
// One item per cycle outside reset; each result passes through the time-bucket
// divider (32 stages), then two fmix rounds and the output math.
// Synchronous reset clears the valid pipeline and loads the config defaults; busy is
// high only during reset. The receiver cannot stall; the pipeline always advances.
`default_nettype none
module turbulent_inlet_velocity
  import tiv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [20:0] site_x,
  input  wire logic signed [20:0] site_y,
  input  wire logic signed [20:0] site_z,
  input  wire logic        [31:0] time_step,
  output logic                    done,
  output logic signed      [25:0] vel_x,
  output logic signed      [25:0] vel_y,
  output logic signed      [25:0] vel_z,
  output logic                    outside_radius,
  input  wire logic               wr_en,
  input  wire logic        [2:0]  wr_index,
  input  wire logic        [62:0] wr_data
);
  localparam int OUT_LAT = 48;

  function automatic logic [15:0] round6(input logic [20:0] s);
    logic [20:0] mag;
    logic [15:0] m;
    mag = s[20] ? 21'(~s + 21'd1) : s;
    m = 16'((22'(mag) + 22'd32) >> 6);
    return s[20] ? 16'(~m + 16'd1) : m;
  endfunction

  function automatic logic [25:0] round_sat(input logic signed [41:0] v);
    logic [41:0] a;
    logic [27:0] m;
    a = v[41] ? 42'(-v) : 42'(v);
    m = 28'((a + 42'd8192) >> 14);
    if (!v[41]) return (m > 28'd33554431) ? 26'h1ffffff : m[25:0];
    return (m > 28'd33554432) ? 26'h2000000 : 26'(~m + 28'd1);
  endfunction

  // config registers
  logic [62:0] center;
  logic [47:0] normal;
  logic [19:0] radius;
  logic [23:0] peak;
  logic [15:0] intensity;
  logic [31:0] warm;
  logic [31:0] seed;
  logic [15:0] period;

  always_ff @(posedge clk) begin
    if (rst) begin
      center    <= '0;
      normal    <= 48'd16384;
      radius    <= 20'd128;
      peak      <= '0;
      intensity <= 16'd3277;
      warm      <= '0;
      seed      <= 32'd1;
      period    <= 16'd1;
    end else if (wr_en) begin
      case (wr_index)
        REG_CENTER:    center    <= wr_data;
        REG_NORMAL:    normal    <= wr_data[47:0];
        REG_RADIUS:    radius    <= wr_data[19:0];
        REG_PEAK:      peak      <= wr_data[23:0];
        REG_INTENSITY: intensity <= wr_data[15:0];
        REG_WARM_UP:   warm      <= wr_data[31:0];
        REG_SEED:      seed      <= wr_data[31:0];
        REG_PERIOD:    period    <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] nx, ny, nz;
  assign nx = $signed(normal[15:0]);
  assign ny = $signed(normal[31:16]);
  assign nz = $signed(normal[47:32]);

  logic accept;
  logic [OUT_LAT-1:0] vld;
  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vld[OUT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[OUT_LAT-2:0], accept};
  end

  // S0 input registers
  logic signed [20:0] s0_x, s0_y, s0_z;
  logic [31:0] s0_t;
  always_ff @(posedge clk) begin
    s0_x <= site_x;
    s0_y <= site_y;
    s0_z <= site_z;
    s0_t <= time_step;
  end

  // time bucket, S0 -> S32
  logic [31:0] tb;
  tiv_div #(.NUM_W(32), .DEN_W(16), .Q_W(32)) u_div_tb (
    .clk(clk), .num(s0_t), .den((period == 16'd0) ? 16'd1 : period), .quo(tb)
  );

  logic [47:0] rc_pipe [32];
  logic        ramp_pipe [30];
  always_ff @(posedge clk) begin
    rc_pipe[0]   <= {round6(s0_z), round6(s0_y), round6(s0_x)};
    ramp_pipe[0] <= (warm != 32'd0) && (s0_t < warm);
    for (int i = 1; i < 32; i++) rc_pipe[i] <= rc_pipe[i-1];
    for (int i = 1; i < 30; i++) ramp_pipe[i] <= ramp_pipe[i-1];
  end

  // ramp, S1 -> S25
  logic [55:0] pt1;
  logic [23:0] qb;
  logic [23:0] qb_pipe [5];
  always_ff @(posedge clk) begin
    pt1 <= 56'(peak) * 56'(s0_t);
    qb_pipe[0] <= qb;
    for (int i = 1; i < 5; i++) qb_pipe[i] <= qb_pipe[i-1];
  end
  tiv_div #(.NUM_W(56), .DEN_W(32), .Q_W(24)) u_div_ramp (
    .clk(clk), .num(pt1), .den(warm), .quo(qb)
  );

  // geometry, S1..S5
  logic [39:0] a2;
  logic signed [21:0] d1_x, d1_y, d1_z;
  logic signed [37:0] pd2_x, pd2_y, pd2_z;
  logic [42:0] sq2_x, sq2_y, sq2_z;
  logic signed [39:0] zq;
  logic [39:0] zabs;
  logic [25:0] zmag3;
  logic [44:0] dd3, dd4;
  logic [51:0] zr2_4;
  logic signed [52:0] rsq_s;
  logic [44:0] rsq;
  logic outside4;
  logic [63:0] num5;
  logic signed [43:0] sqx, sqy, sqz;

  assign sqx = d1_x * d1_x;
  assign sqy = d1_y * d1_y;
  assign sqz = d1_z * d1_z;
  assign zq = 40'(pd2_x) + 40'(pd2_y) + 40'(pd2_z);
  assign zabs = zq[39] ? 40'(-zq) : 40'(zq);
  assign rsq_s = $signed({8'd0, dd4}) - $signed({1'b0, zr2_4});
  assign rsq = rsq_s[52] ? 45'd0 : rsq_s[44:0];
  assign outside4 = (a2 == 40'd0) || (rsq > 45'(a2));

  always_ff @(posedge clk) begin
    a2    <= 40'(radius) * 40'(radius);
    d1_x  <= $signed({s0_x[20], s0_x}) - $signed({center[20], center[20:0]});
    d1_y  <= $signed({s0_y[20], s0_y}) - $signed({center[41], center[41:21]});
    d1_z  <= $signed({s0_z[20], s0_z}) - $signed({center[62], center[62:42]});
    pd2_x <= d1_x * nx;
    pd2_y <= d1_y * ny;
    pd2_z <= d1_z * nz;
    sq2_x <= sqx[42:0];
    sq2_y <= sqy[42:0];
    sq2_z <= sqz[42:0];
    zmag3 <= 26'((zabs + 40'd8192) >> 14);
    dd3   <= 45'(sq2_x) + 45'(sq2_y) + 45'(sq2_z);
    zr2_4 <= 52'(zmag3) * 52'(zmag3);
    dd4   <= dd3;
    num5  <= {40'(a2 - rsq[39:0]), 24'd0};
  end

  logic out_pipe [42];
  always_ff @(posedge clk) begin
    out_pipe[0] <= outside4;
    for (int i = 1; i < 42; i++) out_pipe[i] <= out_pipe[i-1];
  end

  // profile, S5 -> S30
  logic [24:0] prof;
  tiv_div #(.NUM_W(64), .DEN_W(40), .Q_W(25)) u_div_prof (
    .clk(clk), .num(num5), .den(a2), .quo(prof)
  );

  // mean speed, S31..S44
  logic [23:0] cur;
  logic [48:0] mean_prod;
  logic [23:0] mean_pipe [14];
  assign cur = ramp_pipe[29] ? qb_pipe[4] : peak;
  assign mean_prod = 49'(cur) * 49'(prof);
  always_ff @(posedge clk) begin
    mean_pipe[0] <= mean_prod[47:24];
    for (int i = 1; i < 14; i++) mean_pipe[i] <= mean_pipe[i-1];
  end

  // hash keys S33, first fmix S37, combined key S38, final hash S42
  logic [63:0] key3_x, key3_y, key3_z, key3_t;
  logic [63:0] h1_x, h1_y, h1_z, h1_t, key38, h2;
  always_ff @(posedge clk) begin
    key3_x <= {{48{rc_pipe[31][15]}}, rc_pipe[31][15:0]};
    key3_y <= {{48{rc_pipe[31][31]}}, rc_pipe[31][31:16]} + KEY_Y;
    key3_z <= {{48{rc_pipe[31][47]}}, rc_pipe[31][47:32]} + KEY_Z;
    key3_t <= {32'd0, tb} + KEY_T;
    key38  <= {32'd0, seed} ^ h1_x ^ h1_y ^ h1_z ^ h1_t;
  end
  tiv_fmix u_fmix_x (.clk(clk), .key(key3_x), .hash(h1_x));
  tiv_fmix u_fmix_y (.clk(clk), .key(key3_y), .hash(h1_y));
  tiv_fmix u_fmix_z (.clk(clk), .key(key3_z), .hash(h1_z));
  tiv_fmix u_fmix_t (.clk(clk), .key(key3_t), .hash(h1_t));
  tiv_fmix u_fmix_k (.clk(clk), .key(key38), .hash(h2));

  // noise factor and velocity, S43..S47
  logic signed [24:0] es;
  logic signed [41:0] prod43;
  logic signed [42:0] fs;
  logic [24:0] f44, speed45;
  logic [48:0] speed_prod;
  logic signed [41:0] vp46_x, vp46_y, vp46_z;

  assign es = $signed({1'b0, h2[UNIT_BITS-1:UNIT_BITS-24]}) - 25'sd8388608;
  assign fs = 43'(prod43) + 43'sd549755813888;
  assign speed_prod = 49'(mean_pipe[13]) * 49'(f44);

  always_ff @(posedge clk) begin
    prod43  <= $signed({1'b0, intensity}) * es;
    f44     <= (fs > 43'sd0) ? fs[39:15] : 25'd0;
    speed45 <= speed_prod[48:24];
    vp46_x  <= nx * $signed({1'b0, speed45});
    vp46_y  <= ny * $signed({1'b0, speed45});
    vp46_z  <= nz * $signed({1'b0, speed45});
    outside_radius <= out_pipe[41];
    vel_x <= out_pipe[41] ? 26'sd0 : $signed(round_sat(vp46_x));
    vel_y <= out_pipe[41] ? 26'sd0 : $signed(round_sat(vp46_y));
    vel_z <= out_pipe[41] ? 26'sd0 : $signed(round_sat(vp46_z));
  end

  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##OUT_LAT done)
    else $error("item result missing at fixed latency");

  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, OUT_LAT))
    else $error("result without matching item");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    done && outside_radius |-> vel_x == 26'sd0 && vel_y == 26'sd0 && vel_z == 26'sd0)
    else $error("nonzero velocity outside radius");
endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the turbulent inlet velocity block.
module tb
  import tiv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [25:0] vx, vy, vz;
    logic               outside;
  } velocity_t;

  class velocity_scoreboard;
    logic [62:0] center;
    logic [47:0] normal;
    logic [19:0] radius;
    logic [23:0] peak;
    logic [15:0] intensity;
    logic [31:0] warm_up;
    logic [31:0] seed;
    logic [15:0] period;
    velocity_t   pending[$];
    int          errors;
    int          checked;
    int          outside_seen;

    function new();
      center = '0; normal = 48'd16384; radius = 20'd128; peak = '0;
      intensity = 16'd3277; warm_up = '0; seed = 32'd1; period = 16'd1;
      errors = 0; checked = 0; outside_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [62:0] val);
      case (idx)
        REG_CENTER:    center = val;
        REG_NORMAL:    normal = val[47:0];
        REG_RADIUS:    radius = val[19:0];
        REG_PEAK:      peak = val[23:0];
        REG_INTENSITY: intensity = val[15:0];
        REG_WARM_UP:   warm_up = val[31:0];
        REG_SEED:      seed = val[31:0];
        REG_PERIOD:    period = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] mix64(logic [63:0] k);
      k = k ^ (k >> 33);
      k = k * 64'hff51afd7ed558ccd;
      k = k ^ (k >> 33);
      k = k * 64'hc4ceb9fe1a85ec53;
      k = k ^ (k >> 33);
      return k;
    endfunction

    function longint rnd_shift(longint v, int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -m : m;
    endfunction

    function void note_item(logic signed [20:0] sx, sy, sz, logic [31:0] t);
      velocity_t r;
      longint s[3], d[3], n[3], dd, zq, zr, rsq, v;
      logic [63:0] a2, prof, cur, mean, tbk, key, h, e, f, spd;
      longint fs;
      s[0] = sx; s[1] = sy; s[2] = sz;
      dd = 0; zq = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = s[i] - longint'($signed(center[21*i +: 21]));
        n[i] = longint'($signed(normal[16*i +: 16]));
        dd += d[i] * d[i];
        zq += d[i] * n[i];
      end
      zr = rnd_shift(zq, 14);
      rsq = dd - zr * zr;
      if (rsq < 0) rsq = 0;
      a2 = 64'(radius) * 64'(radius);
      r.vx = '0; r.vy = '0; r.vz = '0; r.outside = 1'b1;
      if (a2 != 0 && 64'(rsq) <= a2) begin
        prof = ((a2 - 64'(rsq)) << 24) / a2;
        cur = 64'(peak);
        if (warm_up > 0 && t < warm_up) cur = (64'(peak) * 64'(t)) / 64'(warm_up);
        mean = (cur * prof) >> 24;
        tbk = (period > 0) ? 64'(t) / 64'(period) : 64'(t);
        key = 64'(seed);
        key ^= mix64(64'(rnd_shift(s[0], 6)));
        key ^= mix64(64'(rnd_shift(s[1], 6)) + KEY_Y);
        key ^= mix64(64'(rnd_shift(s[2], 6)) + KEY_Z);
        key ^= mix64(tbk + KEY_T);
        h = mix64(key) & ((64'd1 << 53) - 1);
        e = h >> 29;
        fs = (64'sd1 <<< 39) + longint'(intensity) * (longint'(e) - (64'sd1 <<< 23));
        f = (fs > 0) ? (64'(fs) >> 15) : 64'd0;
        spd = (mean * f) >> 24;
        for (int i = 0; i < 3; i++) begin
          v = rnd_shift(n[i] * longint'(spd), 14);
          if (v > 33554431) v = 33554431;
          if (v < -33554432) v = -33554432;
          if (i == 0) r.vx = v[25:0];
          else if (i == 1) r.vy = v[25:0];
          else r.vz = v[25:0];
        end
        r.outside = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(velocity_t got);
      velocity_t exp_v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result vx=%0d vy=%0d vz=%0d out=%0b", $realtime,
                 got.vx, got.vy, got.vz, got.outside);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      checked++;
      if (got.outside) outside_seen++;
      if (got.vx !== exp_v.vx) begin
        $display("%0t: vel_x expected %0d actual %0d", $realtime, exp_v.vx, got.vx);
        errors++;
      end
      if (got.vy !== exp_v.vy) begin
        $display("%0t: vel_y expected %0d actual %0d", $realtime, exp_v.vy, got.vy);
        errors++;
      end
      if (got.vz !== exp_v.vz) begin
        $display("%0t: vel_z expected %0d actual %0d", $realtime, exp_v.vz, got.vz);
        errors++;
      end
      if (got.outside !== exp_v.outside) begin
        $display("%0t: outside_radius expected %0b actual %0b", $realtime,
                 exp_v.outside, got.outside);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [20:0] site_x = '0, site_y = '0, site_z = '0;
  logic [31:0] time_step = '0;
  logic done;
  logic signed [25:0] vel_x, vel_y, vel_z;
  logic outside_radius;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [62:0] wr_data = '0;

  velocity_scoreboard board;
  int idle_cycles;
  int items_sent;
  localparam int IDLE_LIMIT = 2000;

  always #5 clk = ~clk;

  turbulent_inlet_velocity DUT (.*);

  always @(posedge clk) begin
    velocity_t got;
    if (!rst && done) begin
      got.vx = vel_x; got.vy = vel_y; got.vz = vel_z; got.outside = outside_radius;
      board.check_result(got);
    end
    if ((start && !busy) || done || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL turbulent_inlet_velocity");
      $finish;
    end
  end

  // Registers change only once every item in flight has come back.
  task automatic write_reg(logic [2:0] idx, logic [62:0] val);
    while (board.pending.size() != 0) @(posedge clk);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Drive one item; start stays high across back-to-back items.
  task automatic send_item(logic signed [20:0] sx, sy, sz, logic [31:0] t, bit last_in_burst);
    start <= 1'b1; site_x <= sx; site_y <= sy; site_z <= sz; time_step <= t;
    do @(posedge clk); while (busy);
    board.note_item(sx, sy, sz, t);
    items_sent++;
    if (last_in_burst) start <= 1'b0;
  endtask

  function automatic logic [20:0] q7_near(int r);
    return 21'($signed(r) + $signed($urandom_range(0, 2 * r + 1)) - r);
  endfunction

  task automatic random_phase(int count, int rad);
    int burst;
    int gap;
    bit last_one;
    logic [31:0] t;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(1, 12)) : 0;
      for (int i = 0; i < burst && count > 0; i++) begin
        t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
        last_one = (i == burst - 1 && gap > 0) || count == 1;
        if ($urandom_range(0, 7) == 0)
          send_item(21'($urandom), 21'($urandom), 21'($urandom), t, last_one);
        else
          send_item(q7_near(rad), q7_near(rad), q7_near(rad), t, last_one);
        count--;
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [47:0] pack_normal(int nx, ny, nz);
    return {16'(nz), 16'(ny), 16'(nx)};
  endfunction

  initial begin
    board = new();
    items_sent = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, then extremes
    send_item('0, '0, '0, '0, 1'b0);
    send_item(21'sd100, 21'sd0, 21'sd50, 32'd7, 1'b0);
    send_item(21'sd0, 21'sd129, 21'sd0, 32'd1, 1'b1);
    write_reg(REG_PEAK, 63'd16777215);
    write_reg(REG_INTENSITY, 63'd65535);
    write_reg(REG_RADIUS, 63'd1048575);
    write_reg(REG_NORMAL, 63'(pack_normal(-32768, 32767, -32768)));
    send_item(21'sd1048575, 21'sd1048575, 21'sd1048575, 32'hffffffff, 1'b0);
    send_item(-21'sd1048576, -21'sd1048576, -21'sd1048576, 32'd0, 1'b0);
    send_item('0, '0, '0, 32'h80000000, 1'b0);
    send_item(21'sd63, -21'sd64, 21'sd64, 32'd3, 1'b1);
    write_reg(REG_RADIUS, 63'd0);
    send_item('0, '0, '0, 32'd5, 1'b1);
    write_reg(REG_RADIUS, 63'd200);
    write_reg(REG_NORMAL, 63'(pack_normal(11585, 11585, 0)));
    write_reg(REG_CENTER, {21'sd10, -21'sd20, 21'sd30});
    write_reg(REG_WARM_UP, 63'd1000);
    write_reg(REG_SEED, 63'hffffffff);
    write_reg(REG_PERIOD, 63'd0);
    write_reg(3'(REG_PERIOD), 63'h7fffffffffffffff);
    send_item(21'sd30, -21'sd20, 21'sd10, 32'd0, 1'b0);
    send_item(21'sd30, -21'sd20, 21'sd10, 32'd500, 1'b0);
    send_item(21'sd30, -21'sd20, 21'sd10, 32'd999, 1'b0);
    send_item(21'sd130, 21'sd80, 21'sd10, 32'd1000, 1'b1);
    drain();

    // unit normal along z, moderate radius
    write_reg(REG_CENTER, '0);
    write_reg(REG_NORMAL, 63'(pack_normal(0, 0, 16384)));
    write_reg(REG_RADIUS, 63'd2000);
    write_reg(REG_PEAK, 63'd8000000);
    write_reg(REG_INTENSITY, 63'd3277);
    write_reg(REG_WARM_UP, 63'd0);
    write_reg(REG_SEED, 63'd1);
    write_reg(REG_PERIOD, 63'd1);
    random_phase(350, 2200);
    drain();

    // random config phases
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_CENTER, 63'({$urandom, $urandom}));
      write_reg(REG_NORMAL, 63'({$urandom, $urandom}));
      write_reg(REG_RADIUS, ph == 3 ? 63'd1048575 : 63'($urandom_range(1, 60000)));
      write_reg(REG_PEAK, 63'($urandom));
      write_reg(REG_INTENSITY, 63'($urandom));
      write_reg(REG_WARM_UP, ph[0] ? 63'($urandom_range(0, 3000)) : 63'hffffffff);
      write_reg(REG_SEED, 63'($urandom));
      write_reg(REG_PERIOD, ph == 2 ? 63'd65535 : 63'($urandom_range(0, 300)));
      write_reg(REG_CENTER, '0);
      random_phase(170, ph == 3 ? 1048575 : 40000);
      drain();
    end

    $display("Covered %0d items, %0d results checked, %0d outside the radius,",
             items_sent, board.checked, board.outside_seen);
    $display("over reset, extreme and random register settings.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS turbulent_inlet_velocity");
    end else begin
      $display("FAIL turbulent_inlet_velocity");
    end
    $finish;
  end
endmodule

// File: turbulent_inlet_velocity.f
hdl/tiv_pkg.sv
hdl/tiv_div.sv
hdl/tiv_fmix.sv
hdl/turbulent_inlet_velocity.sv
bench/tb.sv
